/* hdl/cluster_start_proximity_veto_top_assert.svh */
// ----------------------------------------------------------------------------
// Cluster start proximity veto: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_START_PROXIMITY_VETO_TOP_ASSERT_SVH
`define CLUSTER_START_PROXIMITY_VETO_TOP_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define CSPV_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cspv: same-cycle check failed");

// next-cycle implication, clocked on clock, off during reset
`define CSPV_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cspv: next-cycle check failed");

`endif

/* hdl/cspv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster start proximity veto package
// Shared widths, codes, state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package cspv_pkg;

   // default depth of each hit store
   localparam int MAX_HITS_DEF = 256;

   // field widths
   localparam int OP_W      = 3;
   localparam int COORD_W   = 16;
   localparam int HIT_W     = 2 * COORD_W;
   localparam int SEP_W     = 16;
   localparam int MINHITS_W = 9;
   localparam int CSR_IDX_W = 1;
   localparam int TRIG_W    = 2;

   // register reset values
   localparam logic [SEP_W-1:0]     MIN_SEP_RESET  = 16'd51;
   localparam logic [MINHITS_W-1:0] MIN_HITS_RESET = 9'd25;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SEPARATION = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_HITS       = 1'd1;

   // item opcodes
   localparam logic [OP_W-1:0] OP_HIT_ONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_HIT_TWO   = 3'd1;
   localparam logic [OP_W-1:0] OP_START_ONE = 3'd2;
   localparam logic [OP_W-1:0] OP_START_TWO = 3'd3;
   localparam logic [OP_W-1:0] OP_EVAL      = 3'd4;

   // trigger point codes
   typedef enum logic [TRIG_W-1:0] {
      TRIG_NONE  = 2'd0,
      TRIG_START = 2'd1,
      TRIG_LEFT  = 2'd2
   } trig_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_START,
      ST_DRAIN_START,
      ST_SCAN_LEFT,
      ST_DRAIN_LEFT,
      ST_SCAN_HIT,
      ST_DRAIN_HIT,
      ST_FINISH
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic     accept;       // input item taken this cycle
      logic     latch;        // evaluate: pick big cluster, clear counts and start points
      logic     scan_init;    // restart the list walk
      logic     scan_big;     // walk the big list (leftmost search) or the other list
      logic     issue;        // read the next list entry
      logic     clear_close;  // clear the proximity flag
      logic     out_load;     // load the result register
      trig_type out_trig;     // trigger point of the result
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic veto_en;    // big cluster is non-empty and holds at least min_hits hits
      logic scan_done;  // every entry of the walked list was issued
      logic pipe_busy;  // reads or distance stages still in flight
      logic close;      // a hit lay closer than min_separation
      logic out_busy;   // result register holds an item not yet taken
   } status_type;

endpackage

/* hdl/cspv_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster start proximity veto datapath
// Hit stores, counts, start points, list walker, leftmost search,
// squared distance pipeline and result register.
// ----------------------------------------------------------------------------
module cspv_datapath #(
   parameter int MAX_HITS = cspv_pkg::MAX_HITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cspv_pkg::cmd_type                 cmd,
   output cspv_pkg::status_type              status,
   input  logic [cspv_pkg::OP_W-1:0]         opcode,
   input  logic signed [cspv_pkg::COORD_W-1:0] coord_w,
   input  logic signed [cspv_pkg::COORD_W-1:0] coord_t,
   input  logic                              csr_valid,
   input  logic [cspv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cspv_pkg::SEP_W-1:0]        csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_prohibit,
   output logic [cspv_pkg::TRIG_W-1:0]       rsp_trigger_point
);
   import cspv_pkg::*;

   localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int NW = (CW > MINHITS_W) ? CW : MINHITS_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_HITS);

   // configuration registers
   logic [SEP_W-1:0]     min_sep_ff;
   logic [MINHITS_W-1:0] min_hits_ff;
   logic [2*SEP_W-1:0]   lim2_ff;

   // hit stores
   logic [HIT_W-1:0] mem_one [MAX_HITS];
   logic [HIT_W-1:0] mem_two [MAX_HITS];
   logic [HIT_W-1:0] rd_one_ff, rd_two_ff;

   // cluster state
   logic [CW-1:0]    count_one_ff, count_one_in, count_two_ff, count_two_in;
   logic [HIT_W-1:0] start_one_ff, start_one_in, start_two_ff, start_two_in;
   logic             wr_one, wr_two;
   logic [HIT_W-1:0] packed_hit;

   // evaluate state
   logic             sel_two_ff;
   logic [CW-1:0]    nbig_ff, nother_ff;
   logic [HIT_W-1:0] ref_ff;
   logic             first_ff;

   // list walker
   logic [CW-1:0] scan_idx_ff, scan_lim_ff;
   logic          scan_big_ff;

   // pipeline
   logic                      s1_valid_ff, s1_big_ff;
   logic [HIT_W-1:0]          s1_data;
   logic signed [COORD_W-1:0] s1_w, s1_t, ref_w, ref_t;
   logic                      d_valid_ff;
   logic signed [COORD_W:0]   dw_ff, dt_ff;
   logic signed [2*COORD_W+1:0] prod_w, prod_t;
   logic                      sq_valid_ff;
   logic [HIT_W-1:0]          sqw_ff, sqt_ff;
   logic [HIT_W:0]            sq_sum;
   logic                      close_ff;

   // result register
   logic     rsp_valid_ff;
   trig_type trig_ff;

   assign packed_hit = {coord_w, coord_t};

   // configuration writes, squared limit registered from the stored separation
   always_ff @(posedge clock) begin
      if (reset) begin
         min_sep_ff  <= MIN_SEP_RESET;
         min_hits_ff <= MIN_HITS_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_MIN_SEPARATION) begin
            min_sep_ff <= csr_data;
         end else if (csr_index == REG_MIN_HITS) begin
            min_hits_ff <= csr_data[MINHITS_W-1:0];
         end
      end
      lim2_ff <= (2*SEP_W)'(min_sep_ff) * (2*SEP_W)'(min_sep_ff);
   end

   // loads, start points and clearing on evaluate
   always_comb begin
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      start_one_in = start_one_ff;
      start_two_in = start_two_ff;
      wr_one       = 1'b0;
      wr_two       = 1'b0;
      if (cmd.latch) begin
         count_one_in = '0;
         count_two_in = '0;
         start_one_in = '0;
         start_two_in = '0;
      end else if (cmd.accept) begin
         case (opcode)
            OP_HIT_ONE: begin
               if (count_one_ff < CNT_MAX) begin
                  wr_one       = 1'b1;
                  count_one_in = count_one_ff + CW'(1);
               end
            end
            OP_HIT_TWO: begin
               if (count_two_ff < CNT_MAX) begin
                  wr_two       = 1'b1;
                  count_two_in = count_two_ff + CW'(1);
               end
            end
            OP_START_ONE: start_one_in = packed_hit;
            OP_START_TWO: start_two_in = packed_hit;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_one_ff <= '0;
         count_two_ff <= '0;
         start_one_ff <= '0;
         start_two_ff <= '0;
      end else begin
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
         start_one_ff <= start_one_in;
         start_two_ff <= start_two_in;
      end
   end

   // hit stores: one write and one registered read each
   always_ff @(posedge clock) begin
      if (wr_one) begin
         mem_one[count_one_ff[AW-1:0]] <= packed_hit;
      end
      rd_one_ff <= mem_one[scan_idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_two) begin
         mem_two[count_two_ff[AW-1:0]] <= packed_hit;
      end
      rd_two_ff <= mem_two[scan_idx_ff[AW-1:0]];
   end

   // big cluster pick, tie goes to cluster two
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         sel_two_ff <= !(count_one_ff > count_two_ff);
         nbig_ff    <= (count_one_ff > count_two_ff) ? count_one_ff : count_two_ff;
         nother_ff  <= (count_one_ff > count_two_ff) ? count_two_ff : count_one_ff;
      end
   end

   // list walker
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         scan_lim_ff <= '0;
         scan_big_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         scan_idx_ff <= '0;
         scan_lim_ff <= cmd.scan_big ? nbig_ff : nother_ff;
         scan_big_ff <= cmd.scan_big;
      end else if (cmd.issue) begin
         scan_idx_ff <= scan_idx_ff + CW'(1);
      end
   end

   // read stage tag
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
      s1_big_ff <= scan_big_ff;
   end

   assign s1_data = (s1_big_ff == sel_two_ff) ? rd_two_ff : rd_one_ff;
   assign s1_w    = s1_data[HIT_W-1:COORD_W];
   assign s1_t    = s1_data[COORD_W-1:0];
   assign ref_w   = ref_ff[HIT_W-1:COORD_W];
   assign ref_t   = ref_ff[COORD_W-1:0];

   // reference point: start of the big cluster, then its first hit with smallest w
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ref_ff <= (count_one_ff > count_two_ff) ? start_one_ff : start_two_ff;
      end else if (s1_valid_ff && s1_big_ff && (first_ff || (s1_w < ref_w))) begin
         ref_ff <= s1_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (cmd.scan_init && cmd.scan_big) begin
         first_ff <= 1'b1;
      end else if (s1_valid_ff && s1_big_ff) begin
         first_ff <= 1'b0;
      end
   end

   // distance stage one: coordinate differences
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= s1_valid_ff && !s1_big_ff;
      end
      dw_ff <= (COORD_W+1)'(s1_w) - (COORD_W+1)'(ref_w);
      dt_ff <= (COORD_W+1)'(s1_t) - (COORD_W+1)'(ref_t);
   end

   // distance stage two: squares, each fits 32 bits unsigned
   assign prod_w = (2*COORD_W+2)'(dw_ff) * (2*COORD_W+2)'(dw_ff);
   assign prod_t = (2*COORD_W+2)'(dt_ff) * (2*COORD_W+2)'(dt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= d_valid_ff;
      end
      sqw_ff <= prod_w[HIT_W-1:0];
      sqt_ff <= prod_t[HIT_W-1:0];
   end

   // distance stage three: sum and compare against squared limit
   assign sq_sum = {1'b0, sqw_ff} + {1'b0, sqt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         close_ff <= 1'b0;
      end else if (cmd.clear_close) begin
         close_ff <= 1'b0;
      end else if (sq_valid_ff && (sq_sum < {1'b0, lim2_ff})) begin
         close_ff <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         trig_ff <= cmd.out_trig;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prohibit      = (trig_ff != TRIG_NONE);
   assign rsp_trigger_point = trig_ff;

   // status to the controller
   assign status.veto_en   = (NW'(nbig_ff) >= NW'(min_hits_ff)) && (nbig_ff != '0);
   assign status.scan_done = (scan_idx_ff == scan_lim_ff);
   assign status.pipe_busy = s1_valid_ff || d_valid_ff || sq_valid_ff;
   assign status.close     = close_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

endmodule

/* hdl/cspv_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster start proximity veto controller
// Takes items, sequences the start-point check, the leftmost search and
// the leftmost-hit check, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cspv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [cspv_pkg::OP_W-1:0] req_opcode,
   output logic                      req_ready,
   input  cspv_pkg::status_type      status,
   output cspv_pkg::cmd_type         cmd
);
   import cspv_pkg::*;

   state_type state_ff, state_in;
   trig_type  trig_ff, trig_in;

   // state and pending trigger code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         trig_ff  <= TRIG_NONE;
      end else begin
         state_ff <= state_in;
         trig_ff  <= trig_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      trig_in         = trig_ff;
      req_ready       = 1'b0;
      cmd.accept      = 1'b0;
      cmd.latch       = 1'b0;
      cmd.scan_init   = 1'b0;
      cmd.scan_big    = 1'b0;
      cmd.issue       = 1'b0;
      cmd.clear_close = 1'b0;
      cmd.out_load    = 1'b0;
      cmd.out_trig    = trig_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && (req_opcode == OP_EVAL)) begin
               cmd.latch = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.veto_en) begin
               cmd.scan_init   = 1'b1;
               cmd.clear_close = 1'b1;
               state_in        = ST_SCAN_START;
            end else begin
               trig_in  = TRIG_NONE;
               state_in = ST_FINISH;
            end
         end
         // other list against the start point
         ST_SCAN_START: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN_START;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN_START: begin
            if (!status.pipe_busy) begin
               if (status.close) begin
                  trig_in  = TRIG_START;
                  state_in = ST_FINISH;
               end else begin
                  cmd.scan_init = 1'b1;
                  cmd.scan_big  = 1'b1;
                  state_in      = ST_SCAN_LEFT;
               end
            end
         end
         // big list walk for the leftmost hit
         ST_SCAN_LEFT: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN_LEFT;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN_LEFT: begin
            if (!status.pipe_busy) begin
               cmd.scan_init   = 1'b1;
               cmd.clear_close = 1'b1;
               state_in        = ST_SCAN_HIT;
            end
         end
         // other list against the leftmost hit
         ST_SCAN_HIT: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN_HIT;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN_HIT: begin
            if (!status.pipe_busy) begin
               trig_in  = status.close ? TRIG_LEFT : TRIG_NONE;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/cluster_start_proximity_veto_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster start proximity veto, top level
// Loads hits and start points of two clusters; an evaluate item returns
// whether merging the pair is prohibited and which point triggered it.
// ----------------------------------------------------------------------------
// Usage:
//   req_ items carry an opcode in tuser and a (w, t) point in tdata. Hit and
//   start-point loads are taken one per cycle outside an evaluate and give no result.
//   An evaluate item gives one rsp_ item and clears both clusters.
//   csr_ writes set min_separation (index 0) and min_hits (index 1); csr_ready
//   is always high, write only while no evaluate is in flight.
// Evaluate sequence:
//   When the veto applies, an evaluate walks the other list, then the big list
//   and the other list again, each through the single read port of its hit
//   store, one entry a cycle into a four-stage squared-distance pipeline (read,
//   difference, square, compare); otherwise it goes straight to the result.
//   req_tready is low from the accepted evaluate until its result is loaded.
// Reset and stall:
//   Reset empties both clusters, zeroes the start points and restores the
//   register defaults; stored hits are not cleared. When rsp_tready is low the
//   result waits in the output register while loads keep being accepted; a
//   following evaluate waits for the register to empty.
// ----------------------------------------------------------------------------
`include "cluster_start_proximity_veto_top_assert.svh"

module cluster_start_proximity_veto_top #(
   parameter int MAX_HITS = cspv_pkg::MAX_HITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [2*cspv_pkg::COORD_W-1:0] req_tdata,   // coord_w [15:0], coord_t [31:16]
   input  logic [cspv_pkg::OP_W-1:0]      req_tuser,   // opcode [2:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // prohibit [0], trigger_point [2:1]
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cspv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cspv_pkg::SEP_W-1:0]     csr_data
);
   import cspv_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic                rsp_prohibit;
   logic [TRIG_W-1:0]   rsp_trigger_point;

   assign csr_ready = 1'b1;

   cspv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_tuser),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cspv_datapath #(
      .MAX_HITS (MAX_HITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .opcode            (req_tuser),
      .coord_w           (req_tdata[COORD_W-1:0]),
      .coord_t           (req_tdata[2*COORD_W-1:COORD_W]),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_ready         (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_prohibit      (rsp_prohibit),
      .rsp_trigger_point (rsp_trigger_point)
   );

   // result packing, upper bits zero
   assign rsp_tdata = {5'd0, rsp_trigger_point, rsp_prohibit};

   // an accepted evaluate closes the input until its result is out
   `CSPV_ASSERT_NXT(a_eval_blocks_input,
      req_tvalid && req_tready && (req_tuser == OP_EVAL), !req_tready)

   // a new result only follows a cycle with the input closed
   `CSPV_ASSERT_IMP(a_result_after_eval, $rose(rsp_tvalid), !$past(req_tready))

   // prohibit and trigger point agree
   `CSPV_ASSERT_IMP(a_prohibit_matches_trigger, rsp_tvalid,
      rsp_tdata[0] == (rsp_tdata[2:1] != TRIG_NONE))

endmodule
